// ----- design/flipbook_frame_sequencer_macros.svh -----
// assertion helpers for the flipbook_frame_sequencer module
`ifndef FLIPBOOK_FRAME_SEQUENCER_MACROS_SVH
`define FLIPBOOK_FRAME_SEQUENCER_MACROS_SVH

// same-cycle implication
`define FFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ffs_pkg.sv -----
`timescale 1ns / 1ps

package ffs_pkg;

  localparam int FRAME_BITS   = 8;
  localparam int US_BITS      = 24;
  localparam int DELTA_BITS   = 16;
  localparam int ELAPSED_BITS = 32;
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 5;
  localparam int CNT_BITS     = $clog2(ELAPSED_BITS);
  // steps are saturated below 2^(FRAME_BITS+1), plus one
  localparam int STEP_BITS    = FRAME_BITS + 2;

  localparam logic [US_BITS-1:0] PERIOD_RESET = 24'd33333;

  // loop modes; the two unused codes behave as linear wrap
  localparam logic [1:0] LOOP_NONE = 2'd0;
  localparam logic [1:0] LOOP_PING = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_SET
  } cmd_t;

  typedef enum logic [2:0] {
    REG_START_FRAME,
    REG_END_FRAME,
    REG_LOOP_START_FRAME,
    REG_LOOP_MODE,
    REG_FRAME_PERIOD,
    REG_START_DELAY,
    REG_LOOP_DELAY,
    REG_REVERSE_DELAY
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_DIV,
    ST_STEP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] start_frame;
    logic [FRAME_BITS-1:0] end_frame;
    logic [FRAME_BITS-1:0] loop_start_frame;
    logic [1:0]            loop_mode;
    logic [US_BITS-1:0]    frame_period;
    logic [US_BITS-1:0]    start_delay;
    logic [US_BITS-1:0]    loop_delay;
    logic [US_BITS-1:0]    reverse_delay;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic [ELAPSED_BITS-1:0] dividend;
    logic [US_BITS-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [ELAPSED_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/ffs_regs.sv -----
`timescale 1ns / 1ps

module ffs_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffs_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [ffs_pkg::DATA_BITS-1:0]    pwdata,
  output logic [ffs_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready,
  output ffs_pkg::cfg_t                    cfg,
  output logic                             mode_fwd
);

  ffs_pkg::cfg_t     cfg_r, cfg_nxt;
  ffs_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = ffs_pkg::reg_idx_t'(paddr[ffs_pkg::ADDR_BITS-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // writing any loop mode other than ping-pong puts the direction back to forward
  assign mode_fwd = wr && (idx == ffs_pkg::REG_LOOP_MODE) &&
                    (pwdata[1:0] != ffs_pkg::LOOP_PING);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        ffs_pkg::REG_START_FRAME:
          cfg_nxt.start_frame = pwdata[ffs_pkg::FRAME_BITS-1:0];
        ffs_pkg::REG_END_FRAME:
          cfg_nxt.end_frame = pwdata[ffs_pkg::FRAME_BITS-1:0];
        ffs_pkg::REG_LOOP_START_FRAME:
          cfg_nxt.loop_start_frame = pwdata[ffs_pkg::FRAME_BITS-1:0];
        ffs_pkg::REG_LOOP_MODE:
          cfg_nxt.loop_mode = pwdata[1:0];
        ffs_pkg::REG_FRAME_PERIOD:
          cfg_nxt.frame_period = pwdata[ffs_pkg::US_BITS-1:0];
        ffs_pkg::REG_START_DELAY:
          cfg_nxt.start_delay = pwdata[ffs_pkg::US_BITS-1:0];
        ffs_pkg::REG_LOOP_DELAY:
          cfg_nxt.loop_delay = pwdata[ffs_pkg::US_BITS-1:0];
        ffs_pkg::REG_REVERSE_DELAY:
          cfg_nxt.reverse_delay = pwdata[ffs_pkg::US_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ffs_pkg::REG_START_FRAME:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.start_frame);
      ffs_pkg::REG_END_FRAME:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.end_frame);
      ffs_pkg::REG_LOOP_START_FRAME:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.loop_start_frame);
      ffs_pkg::REG_LOOP_MODE:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.loop_mode);
      ffs_pkg::REG_FRAME_PERIOD:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.frame_period);
      ffs_pkg::REG_START_DELAY:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.start_delay);
      ffs_pkg::REG_LOOP_DELAY:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.loop_delay);
      ffs_pkg::REG_REVERSE_DELAY:
        prdata = ffs_pkg::DATA_BITS'(cfg_r.reverse_delay);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_frame      <= '0;
      cfg_r.end_frame        <= '0;
      cfg_r.loop_start_frame <= '0;
      cfg_r.loop_mode        <= ffs_pkg::LOOP_NONE;
      cfg_r.frame_period     <= ffs_pkg::PERIOD_RESET;
      cfg_r.start_delay      <= '0;
      cfg_r.loop_delay       <= '0;
      cfg_r.reverse_delay    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/ffs_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module ffs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ffs_pkg::div_req_t req,
  output ffs_pkg::div_rsp_t rsp
);

  logic [ffs_pkg::ELAPSED_BITS-1:0] dvd_r, dvd_nxt;
  logic [ffs_pkg::US_BITS-1:0]      rem_r, rem_nxt;
  logic [ffs_pkg::US_BITS-1:0]      dvs_r, dvs_nxt;
  logic [ffs_pkg::CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [ffs_pkg::US_BITS:0]        trial;
  logic [ffs_pkg::US_BITS+1:0]      diff;
  logic                             borrow;

  assign trial  = {rem_r, dvd_r[ffs_pkg::ELAPSED_BITS-1]};
  assign diff   = {1'b0, trial} - {2'b00, dvs_r};
  assign borrow = diff[ffs_pkg::US_BITS+1];

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = ffs_pkg::CNT_BITS'(ffs_pkg::ELAPSED_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder always stays below the divisor, so it fits the narrow width
      rem_nxt = borrow ? trial[ffs_pkg::US_BITS-1:0] : diff[ffs_pkg::US_BITS-1:0];
      dvd_nxt = {dvd_r[ffs_pkg::ELAPSED_BITS-2:0], ~borrow};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// ----- design/flipbook_frame_sequencer.sv -----
`timescale 1ns / 1ps
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// command   | in_valid / in_ready     | in_cmd, in_delta_time, in_frame_value
// result    | out_valid / out_ready   | out_frame_index, out_shown, out_playing
// registers | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// one request at a time: start, stop, set and ticks while stopped pass through EXEC and FIN
// a running tick that steps no frame passes through EXEC, CHECK and FIN
// a tick that advances the frame goes through EXEC, CHECK, DIV, STEP and FIN, waiting in DIV for the serial divider
// rst_n is synchronous: stopped, frame 0, forward, period 33333
// a result held by out_ready low stalls the next result but not the next acceptance

module flipbook_frame_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_cmd,
  input  logic [ffs_pkg::DELTA_BITS-1:0]   in_delta_time,
  input  logic [ffs_pkg::FRAME_BITS-1:0]   in_frame_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ffs_pkg::FRAME_BITS-1:0]   out_frame_index,
  output logic                             out_shown,
  output logic                             out_playing,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffs_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [ffs_pkg::DATA_BITS-1:0]    pwdata,
  output logic [ffs_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready
);

`include "flipbook_frame_sequencer_macros.svh"

  localparam int FB = ffs_pkg::FRAME_BITS;
  localparam int EB = ffs_pkg::ELAPSED_BITS;
  localparam int UB = ffs_pkg::US_BITS;
  localparam int SB = ffs_pkg::STEP_BITS;

  ffs_pkg::cfg_t     cfg;
  logic              mode_fwd;
  ffs_pkg::div_req_t div_req;
  ffs_pkg::div_rsp_t div_rsp;

  ffs_pkg::state_t   state_r, state_nxt;
  ffs_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [ffs_pkg::DELTA_BITS-1:0] delta_r, delta_nxt;
  logic [FB-1:0]     fv_r, fv_nxt;
  logic [EB-1:0]     elapsed_r, elapsed_nxt;
  logic [FB-1:0]     cur_r, cur_nxt;
  logic [FB-1:0]     prev_r, prev_nxt;
  logic              rev_r, rev_nxt;
  logic              running_r, running_nxt;
  logic              await_r, await_nxt;
  logic              shown_r, shown_nxt;
  logic [UB:0]       need_r, need_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FB-1:0]     out_frame_r, out_frame_nxt;
  logic              out_shown_r, out_shown_nxt;
  logic              out_playing_r, out_playing_nxt;

  logic [UB-1:0]     period_eff;
  logic [UB-1:0]     hold;
  logic              intro;
  logic [EB:0]       sum;
  logic [EB-1:0]     sum_sat;
  logic [EB:0]       sd_diff;
  logic [EB:0]       need_diff;
  logic              go_div;
  logic              out_free;
  logic [FB:0]       qsat;
  logic [SB-1:0]     steps;
  logic [SB-1:0]     cur_ext;
  logic [SB-1:0]     end_ext;
  logic [SB-1:0]     ls_ext;
  logic [SB-1:0]     next_f;

  ffs_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .mode_fwd (mode_fwd)
  );

  ffs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign period_eff = (cfg.frame_period == '0) ? UB'(1) : cfg.frame_period;

  // the loop start frame is not held while the intro runs up into it
  assign intro = (prev_r < cur_r) && (cfg.start_frame != cfg.loop_start_frame);

  always_comb begin
    hold = '0;
    if (cfg.loop_mode != ffs_pkg::LOOP_NONE) begin
      if (cur_r == cfg.loop_start_frame && !intro) begin
        hold = cfg.loop_delay;
      end else if (cfg.loop_mode == ffs_pkg::LOOP_PING && cur_r == cfg.end_frame && rev_r) begin
        hold = cfg.reverse_delay;
      end
    end
  end

  assign sum       = {1'b0, elapsed_r} + (EB + 1)'(delta_r);
  assign sum_sat   = sum[EB] ? '1 : sum[EB-1:0];
  assign sd_diff   = {1'b0, elapsed_r} - (EB + 1)'(cfg.start_delay);
  assign need_diff = {1'b0, elapsed_r} - (EB + 1)'(need_r);
  assign go_div    = (state_r == ffs_pkg::ST_CHECK) && !await_r && !need_diff[EB];
  assign out_free  = !out_valid_r || out_ready;

  // any quotient past twice the frame range lands on the same end case
  assign qsat    = (|div_rsp.quotient[EB-1:FB+1]) ? '1 : div_rsp.quotient[FB:0];
  assign steps   = {1'b0, qsat} + SB'(1);
  assign cur_ext = SB'(cur_r);
  assign end_ext = SB'(cfg.end_frame);
  assign ls_ext  = SB'(cfg.loop_start_frame);

  always_comb begin
    if (rev_r) begin
      next_f = (steps >= cur_ext) ? '0 : cur_ext - steps;
    end else begin
      next_f = cur_ext + steps;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffs_pkg::ST_IDLE:
        if (in_valid) state_nxt = ffs_pkg::ST_EXEC;
      ffs_pkg::ST_EXEC:
        if (cmd_r == ffs_pkg::CMD_TICK && running_r) state_nxt = ffs_pkg::ST_CHECK;
        else state_nxt = ffs_pkg::ST_FIN;
      ffs_pkg::ST_CHECK:
        if (go_div) state_nxt = ffs_pkg::ST_DIV;
        else state_nxt = ffs_pkg::ST_FIN;
      ffs_pkg::ST_DIV:
        if (div_rsp.done) state_nxt = ffs_pkg::ST_STEP;
      ffs_pkg::ST_STEP:
        state_nxt = ffs_pkg::ST_FIN;
      ffs_pkg::ST_FIN:
        if (out_free) state_nxt = ffs_pkg::ST_IDLE;
      default: state_nxt = ffs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready         = (state_r == ffs_pkg::ST_IDLE);
    div_req.start    = go_div;
    div_req.dividend = need_diff[EB-1:0];
    div_req.divisor  = period_eff;
  end

  // datapath
  always_comb begin
    cmd_nxt         = cmd_r;
    delta_nxt       = delta_r;
    fv_nxt          = fv_r;
    elapsed_nxt     = elapsed_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    rev_nxt         = rev_r;
    running_nxt     = running_r;
    await_nxt       = await_r;
    shown_nxt       = shown_r;
    need_nxt        = need_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_frame_nxt   = out_frame_r;
    out_shown_nxt   = out_shown_r;
    out_playing_nxt = out_playing_r;

    if (mode_fwd) rev_nxt = 1'b0;

    case (state_r)
      ffs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = ffs_pkg::cmd_t'(in_cmd);
          delta_nxt = in_delta_time;
          fv_nxt    = in_frame_value;
        end
      end
      ffs_pkg::ST_EXEC: begin
        shown_nxt = 1'b0;
        need_nxt  = {1'b0, period_eff} + {1'b0, hold};
        unique case (cmd_r)
          ffs_pkg::CMD_TICK: begin
            if (running_r) elapsed_nxt = sum_sat;
          end
          ffs_pkg::CMD_START: begin
            cur_nxt     = cfg.start_frame;
            rev_nxt     = 1'b0;
            running_nxt = 1'b1;
            elapsed_nxt = '0;
            await_nxt   = (cfg.start_delay != '0);
            shown_nxt   = (cfg.start_delay == '0);
          end
          ffs_pkg::CMD_STOP: begin
            running_nxt = 1'b0;
          end
          ffs_pkg::CMD_SET: begin
            if (fv_r >= cfg.start_frame && fv_r <= cfg.end_frame) begin
              cur_nxt   = fv_r;
              shown_nxt = 1'b1;
              if (running_r) elapsed_nxt = '0;
            end
          end
          default: shown_nxt = 1'b0;
        endcase
      end
      ffs_pkg::ST_CHECK: begin
        if (await_r && !sd_diff[EB]) begin
          await_nxt   = 1'b0;
          elapsed_nxt = '0;
          shown_nxt   = 1'b1;
        end
      end
      ffs_pkg::ST_STEP: begin
        prev_nxt    = cur_r;
        elapsed_nxt = '0;
        shown_nxt   = 1'b1;
        if (cfg.loop_mode == ffs_pkg::LOOP_NONE) begin
          if (next_f > end_ext) begin
            cur_nxt     = cfg.end_frame;
            running_nxt = 1'b0;
          end else begin
            cur_nxt = next_f[FB-1:0];
          end
        end else if (cfg.loop_mode == ffs_pkg::LOOP_PING) begin
          if (!rev_r && next_f >= end_ext) begin
            rev_nxt = 1'b1;
            cur_nxt = cfg.end_frame;
          end else if (rev_r && next_f <= ls_ext) begin
            rev_nxt = 1'b0;
            cur_nxt = cfg.loop_start_frame;
          end else begin
            cur_nxt = next_f[FB-1:0];
          end
        end else begin
          cur_nxt = (next_f > end_ext) ? cfg.loop_start_frame : next_f[FB-1:0];
        end
      end
      ffs_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_frame_nxt   = cur_r;
          out_shown_nxt   = shown_r;
          out_playing_nxt = running_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffs_pkg::ST_IDLE;
      elapsed_r   <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      rev_r       <= 1'b0;
      running_r   <= 1'b0;
      await_r     <= 1'b0;
      shown_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      rev_r       <= rev_nxt;
      running_r   <= running_nxt;
      await_r     <= await_nxt;
      shown_r     <= shown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    delta_r       <= delta_nxt;
    fv_r          <= fv_nxt;
    need_r        <= need_nxt;
    out_frame_r   <= out_frame_nxt;
    out_shown_r   <= out_shown_nxt;
    out_playing_r <= out_playing_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_r;
  assign out_shown       = out_shown_r;
  assign out_playing     = out_playing_r;

  `FFS_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == ffs_pkg::ST_DIV, "divider finished outside the division state")
  `FFS_ASSERT_NEXT(a_step_clears_elapsed, clk, rst_n, state_r == ffs_pkg::ST_STEP, elapsed_r == '0 && shown_r, "frame step left elapsed time or shown flag wrong")
  `FFS_ASSERT_NEXT(a_fin_waits_for_slot, clk, rst_n, state_r == ffs_pkg::ST_FIN && out_valid_r && !out_ready, state_r == ffs_pkg::ST_FIN && out_valid_r, "pending result dropped while output stalled")

endmodule
